// ----- design/jsu_pkg.sv -----
// Package for the JSON string unescaper: word types, result kinds and sizing constants.
// Has no dependencies; every design file imports it.
package jsu_pkg;

    // Largest output buffer, terminator included.
    localparam int MAX_CAPACITY = 4096;

    // Widths of the capacity register and of the decoded byte count.
    localparam int CAP_W = 13;
    localparam int LEN_W = 12;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

    // Result kinds.
    localparam logic [2:0] K_DATA   = 3'd0;
    localparam logic [2:0] K_OK     = 3'd1;
    localparam logic [2:0] K_UNTERM = 3'd2;
    localparam logic [2:0] K_TRAIL  = 3'd3;
    localparam logic [2:0] K_SHORT  = 3'd4;
    localparam logic [2:0] K_LONG   = 3'd5;

    // Input word: one byte of the string body.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
    } in_item_t;

    // Output word: one decoded byte or an end-of-string report.
    typedef struct packed {
        logic [7:0]       out_byte;
        logic [2:0]       kind;
        logic [LEN_W-1:0] out_length;
    } out_item_t;

endpackage

// ----- design/json_string_unescaper_top.sv -----
// JSON string unescaper, top level; depends on jsu_pkg and jsu_decode.
// Usage: feed the string body one byte per word, the first byte marked first; each word yields
// at most one output word, either a decoded byte (kind 0) with the running length, or an
// end-of-string report (kind 1 success, 2..5 errors). Bytes after the end are dropped until one
// marked first arrives. The block takes one byte every clock cycle while its result register is free or
// being emptied; each byte passes an input register, one pass of decode logic and a result
// register before its result is presented on the output. Write out_capacity only while no bytes
// are in flight.
module json_string_unescaper_top
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic [CAP_W-1:0] cap_reg;
    logic             advance;
    logic             step;
    logic             res_valid;
    out_item_t        res;

    // The pipeline moves whenever the result register is free or being emptied.
    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    jsu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_item_reg),
        .out_capacity (cap_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_item_reg <= res;
        end
    end

endmodule

// ----- design/jsu_decode.sv -----
// Decoder state and the single-pass decode of one input word into at most one result.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  in_item_t         item,
    input  logic [CAP_W-1:0] out_capacity,
    output logic             res_valid,
    output out_item_t        res
);

    // Decoder modes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_PLAIN = 3'd1;
    localparam logic [2:0] MODE_ESC   = 3'd2;
    localparam logic [2:0] MODE_HEX1  = 3'd3;
    localparam logic [2:0] MODE_HEX4  = 3'd6;

    // Capacity limited to what the count can represent.
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY > 4096 ? 4096 : MAX_CAPACITY);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    logic [2:0]       mode_reg, mode_next;
    logic [7:0]       hex_reg, hex_next;
    logic             stop_reg, stop_next;
    logic [LEN_W-1:0] count_reg, count_next;

    logic [2:0]       mode_eff;
    logic [7:0]       hex_eff;
    logic             stop_eff;
    logic [LEN_W-1:0] count_eff;
    logic [CAP_W-1:0] cap_eff;
    logic [7:0]       c;
    logic             emit_req;
    logic [7:0]       emit_byte;
    logic             fin_req;
    logic [2:0]       fin_kind;
    logic             digit_ok;
    logic [3:0]       digit;
    logic [7:0]       hex_upd;

    assign c       = item.in_byte;
    assign cap_eff = (out_capacity > CAP_LIMIT) ? CAP_LIMIT : out_capacity;

    // A word marked first restarts the decoder before it is decoded.
    assign mode_eff  = item.first ? MODE_PLAIN : mode_reg;
    assign hex_eff   = item.first ? 8'd0 : hex_reg;
    assign stop_eff  = item.first ? 1'b0 : stop_reg;
    assign count_eff = item.first ? '0 : count_reg;

    // Hex digit value of the current byte.
    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            digit = c[3:0];
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            digit = c[3:0] + 4'd9;
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    assign hex_upd = (!stop_eff && digit_ok) ? {hex_eff[3:0], digit} : hex_eff;

    // Mode handling: decide whether this byte emits, ends the string, or just moves on.
    always_comb
    begin
        mode_next  = mode_eff;
        hex_next   = hex_eff;
        stop_next  = stop_eff;
        count_next = count_eff;
        emit_req   = 1'b0;
        emit_byte  = c;
        fin_req    = 1'b0;
        fin_kind   = K_OK;

        if (mode_eff == MODE_PLAIN)
        begin
            if (c == 8'd0)
            begin
                fin_req  = 1'b1;
                fin_kind = K_UNTERM;
            end
            else if (c == CH_QUOTE)
            begin
                fin_req  = 1'b1;
                fin_kind = K_OK;
            end
            else if (c == CH_BSL)
            begin
                mode_next = MODE_ESC;
            end
            else
            begin
                emit_req = 1'b1;
            end
        end
        else if (mode_eff == MODE_ESC)
        begin
            case (c)
                8'h00:
                begin
                    fin_req  = 1'b1;
                    fin_kind = K_TRAIL;
                end
                8'h6E:
                begin
                    emit_req  = 1'b1;
                    emit_byte = 8'h0A;
                end
                8'h72:
                begin
                    emit_req  = 1'b1;
                    emit_byte = 8'h0D;
                end
                8'h74:
                begin
                    emit_req  = 1'b1;
                    emit_byte = 8'h09;
                end
                8'h75:
                begin
                    hex_next  = 8'd0;
                    stop_next = 1'b0;
                    mode_next = MODE_HEX1;
                end
                default:
                begin
                    emit_req = 1'b1;
                end
            endcase
        end
        else if (mode_eff >= MODE_HEX1 && mode_eff <= MODE_HEX4)
        begin
            if (c == 8'd0)
            begin
                fin_req  = 1'b1;
                fin_kind = K_SHORT;
            end
            else
            begin
                hex_next = hex_upd;
                if (stop_eff || !digit_ok)
                begin
                    stop_next = 1'b1;
                end
                if (mode_eff == MODE_HEX4)
                begin
                    emit_req  = 1'b1;
                    emit_byte = hex_upd;
                end
                else
                begin
                    mode_next = mode_eff + 3'd1;
                end
            end
        end

        // A decoded byte either fits the buffer or ends the string as too long.
        if (emit_req)
        begin
            if ({1'b0, count_eff} + CAP_W'(1) >= cap_eff)
            begin
                fin_req  = 1'b1;
                fin_kind = K_LONG;
            end
            else
            begin
                count_next = count_eff + LEN_W'(1);
                mode_next  = MODE_PLAIN;
            end
        end

        if (fin_req)
        begin
            mode_next = MODE_IDLE;
        end
    end

    // Result word.
    always_comb
    begin
        res_valid      = fin_req || emit_req;
        res.out_byte   = fin_req ? 8'd0 : emit_byte;
        res.kind       = fin_req ? fin_kind : K_DATA;
        res.out_length = fin_req ? count_eff : count_next;
    end

    // Decoder state, advanced once per decoded word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            hex_reg   <= 8'd0;
            stop_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            hex_reg   <= hex_next;
            stop_reg  <= stop_next;
            count_reg <= count_next;
        end
    end

    // A data result always advances the count by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.kind == K_DATA |=> count_reg == $past(count_eff) + LEN_W'(1))
        else $error("decoded count did not advance with a data word");

    // Any end-of-string result leaves the decoder discarding.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.kind != K_DATA |=> mode_reg == MODE_IDLE)
        else $error("decoder not discarding after end of string");

    // End reports carry no byte.
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind != K_DATA |-> res.out_byte == 8'd0)
        else $error("end-of-string word carries a byte");

    // While discarding, an unmarked byte produces nothing.
    a_discard: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE && !item.first |-> !res_valid)
        else $error("result produced while discarding");

endmodule

// ----- tb/tb_json_string_unescaper_top.sv -----
// Testbench for the JSON string unescaper: directed and random byte streams with a
// word-level predictor of the decoder, checked word by word on the output channel.
// Depends on jsu_pkg and json_string_unescaper_top.
`timescale 1ns / 1ps

module tb_json_string_unescaper_top;
    import jsu_pkg::*;

    // Decoder modes tracked by the predictor.
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_PLAIN = 3'd1;
    localparam logic [2:0] M_ESC   = 3'd2;
    localparam logic [2:0] M_HEX1  = 3'd3;
    localparam logic [2:0] M_HEX4  = 3'd6;

    // Characters with a meaning inside a string body.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Cycles for a byte to leave the pipeline, with some margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS   = 200;
    localparam int LONG_HOLD     = 300;

    localparam out_item_t NO_RESULT = '0;

    typedef struct {
        in_item_t  word;
        bit        typed;
        out_item_t want;
    } row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_item_t         in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_item;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_data  = CAP_RESET;

    // Predictor state.
    logic [2:0]       mode_q   = M_IDLE;
    logic [7:0]       hex_acc  = '0;
    logic             hex_halt = 1'b0;
    logic [LEN_W-1:0] emitted  = '0;
    logic [CAP_W-1:0] capacity = CAP_RESET;

    out_item_t pending_results [$];
    out_item_t want_word;

    int err_count       = 0;
    int words_taken     = 0;
    int results_checked = 0;
    int cap_writes      = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_req       = 0;
    int stall_seen      = 0;
    int hold_left       = 0;

    string hex_chars = "0123456789abcdefABCDEF";
    row_t  script [25];

    json_string_unescaper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Closes the current string with the given kind.
    function automatic out_item_t end_string(input logic [2:0] k);
        out_item_t r;
        r.out_byte   = '0;
        r.kind       = k;
        r.out_length = emitted;
        mode_q       = M_IDLE;
        return r;
    endfunction

    // Emits one decoded byte, or ends the string when the buffer is full.
    function automatic out_item_t put_byte(input logic [7:0] b);
        out_item_t r;
        int        lim;
        lim = int'(capacity);
        if (lim > MAX_CAPACITY)
            lim = MAX_CAPACITY;
        if (lim > 4096)
            lim = 4096;
        if (int'(emitted) + 1 >= lim)
            return end_string(K_LONG);
        emitted      = emitted + 1'b1;
        mode_q       = M_PLAIN;
        r.out_byte   = b;
        r.kind       = K_DATA;
        r.out_length = emitted;
        return r;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // Advances the predictor by one input word; returns 1 when a result is due.
    function automatic bit decode_byte(input in_item_t w, output out_item_t r);
        logic [7:0] c;
        int         d;
        c = w.in_byte;
        r = NO_RESULT;
        if (w.first)
        begin
            mode_q   = M_PLAIN;
            hex_acc  = '0;
            hex_halt = 1'b0;
            emitted  = '0;
        end
        if (mode_q == M_PLAIN)
        begin
            if (c == CH_NUL)
            begin
                r = end_string(K_UNTERM);
                return 1'b1;
            end
            if (c == CH_QUOTE)
            begin
                r = end_string(K_OK);
                return 1'b1;
            end
            if (c == CH_BSLASH)
            begin
                mode_q = M_ESC;
                return 1'b0;
            end
            r = put_byte(c);
            return 1'b1;
        end
        if (mode_q == M_ESC)
        begin
            if (c == CH_NUL)
                r = end_string(K_TRAIL);
            else if (c == "n")
                r = put_byte(8'h0A);
            else if (c == "r")
                r = put_byte(8'h0D);
            else if (c == "t")
                r = put_byte(8'h09);
            else if (c == "u")
            begin
                hex_acc  = '0;
                hex_halt = 1'b0;
                mode_q   = M_HEX1;
                return 1'b0;
            end
            else
                r = put_byte(c);
            return 1'b1;
        end
        if (mode_q >= M_HEX1 && mode_q <= M_HEX4)
        begin
            if (c == CH_NUL)
            begin
                r = end_string(K_SHORT);
                return 1'b1;
            end
            d = hex_nibble(c);
            if (!hex_halt && d >= 0)
                hex_acc = {hex_acc[3:0], 4'(d)};
            else
                hex_halt = 1'b1;
            if (mode_q == M_HEX4)
            begin
                r = put_byte(hex_acc);
                return 1'b1;
            end
            mode_q = mode_q + 3'd1;
            return 1'b0;
        end
        // Discarding, and the unused mode code, drop the byte.
        return 1'b0;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic flag_mismatch(input string what);
        err_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Books an accepted word: predicted result, or the one typed in the table.
    task automatic take_word(input in_item_t w, input bit typed, input out_item_t want);
        out_item_t r;
        bit        has;
        has = decode_byte(w, r);
        words_taken++;
        if (typed)
            pending_results.push_back(want);
        else if (has)
            pending_results.push_back(r);
    endtask

    // Offers one word, after a random gap, and waits for it to be taken.
    task automatic send_word(input in_item_t w, input bit typed, input out_item_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        take_word(w, typed, want);
    endtask

    // Holds the sender off until every expected result is out and the pipe is empty.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        wait_for_quiet();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity = v;
        cap_writes++;
    endtask

    function automatic logic [7:0] pick_hex();
        return hex_chars[$urandom_range(hex_chars.len() - 1)];
    endfunction

    // Builds one string body, mostly well formed, and sends it.
    task automatic send_string();
        logic [7:0] body [$];
        logic [7:0] b;
        int         ntok;
        int         pick;
        bit         noise;
        in_item_t   w;
        noise = ($urandom_range(99) >= 88);
        // Stray bytes while discarding are simply dropped by the block.
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(1, 3))
            begin
                w.in_byte = 8'($urandom_range(255));
                w.first   = 1'b0;
                send_word(w, 1'b0, NO_RESULT);
            end
        end
        if (noise)
        begin
            repeat ($urandom_range(1, 12))
                body.push_back(8'($urandom_range(255)));
        end
        else
        begin
            ntok = ($urandom_range(99) < 10) ? $urandom_range(10, 40) : $urandom_range(0, 10);
            repeat (ntok)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    body.push_back(b);
                end
                else if (pick < 75)
                begin
                    body.push_back(CH_BSLASH);
                    case ($urandom_range(4))
                        0: body.push_back("n");
                        1: body.push_back("r");
                        2: body.push_back("t");
                        3: body.push_back(CH_QUOTE);
                        default: body.push_back(CH_BSLASH);
                    endcase
                end
                else if (pick < 82)
                begin
                    body.push_back(CH_BSLASH);
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == "u" || b == "n" || b == "r" || b == "t");
                    body.push_back(b);
                end
                else
                begin
                    body.push_back(CH_BSLASH);
                    body.push_back("u");
                    repeat (4)
                        body.push_back(($urandom_range(99) < 80) ? pick_hex() :
                                       8'($urandom_range(1, 255)));
                end
            end
            // Terminator: mostly a quote, otherwise one of the error endings.
            pick = $urandom_range(99);
            if (pick < 80)
                body.push_back(CH_QUOTE);
            else if (pick < 88)
                body.push_back(CH_NUL);
            else if (pick < 94)
            begin
                body.push_back(CH_BSLASH);
                body.push_back(CH_NUL);
            end
            else
            begin
                body.push_back(CH_BSLASH);
                body.push_back("u");
                repeat ($urandom_range(3))
                    body.push_back(pick_hex());
                body.push_back(CH_NUL);
            end
        end
        foreach (body[i])
        begin
            w.in_byte = body[i];
            if (noise)
                w.first = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 10);
            else
                w.first = (i == 0);
            send_word(w, 1'b0, NO_RESULT);
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (stall_req != stall_seen)
        begin
            stall_seen = stall_req;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker: each word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("unexpected word byte=%02h kind=%0d len=%0d",
                              out_item.out_byte, out_item.kind, out_item.out_length));
            else
            begin
                want_word = pending_results.pop_front();
                if (out_item.out_byte !== want_word.out_byte)
                    flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                  out_item.out_byte, want_word.out_byte));
                if (out_item.kind !== want_word.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d",
                                  out_item.kind, want_word.kind));
                if (out_item.out_length !== want_word.out_length)
                    flag_mismatch($sformatf("out_length %0d, expected %0d",
                                  out_item.out_length, want_word.out_length));
            end
        end
    end

    // Stimulus.
    initial
    begin
        int          caps [9];
        int          phase_start;
        bit          paused;
        caps = '{8, 1, 4096, 0, 2, 8191, 30, 3, 256};

        // Directed table: escapes, hex groups, the unterminated, trailing and short-hex endings, discarding.
        script = '{
            '{'{"A", 1'b0},       1'b0, NO_RESULT},
            '{'{CH_QUOTE, 1'b1},  1'b1, '{8'h00, K_OK, 12'd0}},
            '{'{CH_NUL, 1'b1},    1'b1, '{8'h00, K_UNTERM, 12'd0}},
            '{'{CH_BSLASH, 1'b1}, 1'b0, NO_RESULT},
            '{'{CH_NUL, 1'b0},    1'b1, '{8'h00, K_TRAIL, 12'd0}},
            '{'{8'hFF, 1'b1},     1'b1, '{8'hFF, K_DATA, 12'd1}},
            '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RESULT},
            '{'{"n", 1'b0},       1'b1, '{8'h0A, K_DATA, 12'd2}},
            '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RESULT},
            '{'{"t", 1'b0},       1'b1, '{8'h09, K_DATA, 12'd3}},
            '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RESULT},
            '{'{"q", 1'b0},       1'b0, NO_RESULT},
            '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RESULT},
            '{'{"u", 1'b0},       1'b0, NO_RESULT},
            '{'{"F", 1'b0},       1'b0, NO_RESULT},
            '{'{"f", 1'b0},       1'b0, NO_RESULT},
            '{'{"g", 1'b0},       1'b0, NO_RESULT},
            '{'{"9", 1'b0},       1'b0, NO_RESULT},
            '{'{CH_BSLASH, 1'b0}, 1'b0, NO_RESULT},
            '{'{"u", 1'b0},       1'b0, NO_RESULT},
            '{'{CH_QUOTE, 1'b0},  1'b0, NO_RESULT},
            '{'{CH_NUL, 1'b0},    1'b1, '{8'h00, K_SHORT, 12'd5}},
            '{'{8'h7F, 1'b0},     1'b0, NO_RESULT},
            '{'{8'h01, 1'b1},     1'b0, NO_RESULT},
            '{'{CH_QUOTE, 1'b0},  1'b0, NO_RESULT}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 64;
        foreach (script[i])
            send_word(script[i].word, script[i].typed, script[i].want);

        // Random phases: three handshake regimes, three capacity settings each.
        paused = 1'b0;
        for (int p = 0; p < 9; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            set_capacity(CAP_W'(caps[p]));
            phase_start = words_taken;
            while (words_taken - phase_start < PHASE_WORDS)
            begin
                // Long receiver hold-off while the sender keeps offering.
                if (p == 6 && stall_req == 0 && words_taken - phase_start >= 60)
                    stall_req = 1;
                // Sender pause until the block has delivered everything.
                if (p == 4 && !paused && words_taken - phase_start >= 100)
                begin
                    paused = 1'b1;
                    wait_for_quiet();
                end
                send_string();
            end
        end

        wait_for_quiet();
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d expected words never arrived",
                          pending_results.size()));
        $display("Summary: %0d input words taken, %0d output words checked, %0d capacity writes.",
                 words_taken, results_checked, cap_writes);
        $display("Covered escapes, hex groups, all end kinds and three handshake regimes.");
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog on a hung handshake.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
